// ===== rtl/asl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address segment lookup package
// Request, response, table entry and probe result types, register indexes
// and codes shared by the lookup unit and its memory and compare submodules.
// ----------------------------------------------------------------------------
package asl_pkg;

   localparam int COUNT_W = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PHYSICAL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIRTUAL_COUNT  = 2'd1;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = 11'h7FF;

   typedef struct packed {
      logic        req_type;
      logic        space;
      logic [9:0]  entry_index;
      logic [63:0] seg_start;
      logic [63:0] seg_end;
      logic [15:0] first_section;
      logic        has_sections;
      logic [63:0] lookup_offset;
   } asl_req_type;

   typedef struct packed {
      logic        segment_found;
      logic [9:0]  segment_index;
      logic        section_found;
      logic [15:0] section_id;
   } asl_rsp_type;

   typedef struct packed {
      logic [63:0] seg_start;
      logic [63:0] seg_end;
      logic [15:0] first_section;
      logic        has_sections;
   } asl_entry_type;

   typedef struct packed {
      logic hit;
      logic above;
   } asl_probe_type;

endpackage

// ===== rtl/address_segment_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address segment lookup unit
// A lookup probes the last-hit entry, then the entries after and before it,
// and falls back to a binary search when none of them holds the offset.
// One probe a cycle through the single compare unit; the next request is taken
// in the response cycle; a lookup holds busy until it responds, a load does not.
// Reset clears the counts, last-hit records and sequencer; no response stalls.
// ----------------------------------------------------------------------------
module address_segment_lookup_unit #(
   parameter int MAX_SEGMENTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  asl_pkg::asl_req_type                  req_data,
   output logic                                  busy,
   output logic                                  rsp_valid,
   output asl_pkg::asl_rsp_type                  rsp_data,
   input  logic                                  csr_we,
   input  logic [asl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [asl_pkg::COUNT_W-1:0]           csr_wdata
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int NW = IW + 1;
   localparam int XW = (NW > asl_pkg::COUNT_W) ? NW : asl_pkg::COUNT_W;
   localparam int AW = IW + 1;
   localparam logic [XW-1:0] MAX_X = XW'(MAX_SEGMENTS);
   localparam logic [NW-1:0] MAX_N = NW'(MAX_SEGMENTS);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHK_L = 6'b000010,
      ST_CHK_N = 6'b000100,
      ST_CHK_P = 6'b001000,
      ST_SRCH  = 6'b010000,
      ST_FIN   = 6'b100000
   } asl_state_type;

   asl_state_type state_ff, state_in;

   logic [asl_pkg::COUNT_W-1:0] phys_count_ff, virt_count_ff;
   logic                        lh_valid_ff [2];
   logic [IW-1:0]               lh_idx_ff [2];

   logic          space_ff;
   logic [63:0]   off_ff;
   logic [NW-1:0] n_ff;
   logic [IW-1:0] l_ff;
   logic          lv_ff;
   logic [NW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;

   logic                 rsp_valid_ff;
   asl_pkg::asl_rsp_type rsp_ff;

   logic                        accept;
   logic [asl_pkg::COUNT_W-1:0] raw_count;
   logic [NW-1:0]               n_eff;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   asl_pkg::asl_entry_type wr_data;
   logic                   rd_space;
   logic [IW-1:0]          rd_idx;
   asl_pkg::asl_entry_type rd_data;
   asl_pkg::asl_probe_type pr;

   logic [NW-1:0] l_ext, l_nx, l_pv;
   logic          cond_l, cond_n, cond_p;

   logic [NW-1:0] plan_lo, plan_hi, plan_span, plan_mid;
   logic          plan_more;
   logic [IW-1:0] plan_idx;

   logic          done;
   logic          hit_found;
   logic [IW-1:0] hit_idx;

   assign accept = start && !busy;
   assign busy   = state_ff != ST_IDLE;

   always_comb begin
      raw_count = req_data.space ? virt_count_ff : phys_count_ff;
      if (raw_count == asl_pkg::COUNT_ALL_ONES) begin
         n_eff = '0;
      end else if (XW'(raw_count) > MAX_X) begin
         n_eff = MAX_N;
      end else begin
         n_eff = NW'(raw_count);
      end
   end

   assign wr_en = accept && (req_data.req_type == asl_pkg::REQ_LOAD) &&
                  (XW'(req_data.entry_index) < MAX_X);
   assign wr_addr = {req_data.space, IW'(req_data.entry_index)};
   assign wr_data.seg_start     = req_data.seg_start;
   assign wr_data.seg_end       = req_data.seg_end;
   assign wr_data.first_section = req_data.first_section;
   assign wr_data.has_sections  = req_data.has_sections;

   asl_seg_mem #(
      .ADDR_W (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr ({rd_space, rd_idx}),
      .rd_data (rd_data)
   );

   asl_probe u_probe (
      .entry  (rd_data),
      .offset (off_ff),
      .result (pr)
   );

   assign l_ext  = {1'b0, l_ff};
   assign l_nx   = l_ext + NW'(1);
   assign l_pv   = l_ext - NW'(1);
   assign cond_l = lv_ff && (l_ext < n_ff);
   assign cond_n = lv_ff && (l_nx < n_ff);
   assign cond_p = lv_ff && (l_ff != '0) && (l_pv < n_ff);

   assign plan_span = plan_hi - plan_lo;
   assign plan_more = plan_span > NW'(1);
   assign plan_mid  = plan_lo + (plan_span >> 1);
   assign plan_idx  = plan_more ? plan_mid[IW-1:0] : plan_lo[IW-1:0];

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      rd_space  = space_ff;
      rd_idx    = '0;
      plan_lo   = '0;
      plan_hi   = n_ff;
      done      = 1'b0;
      hit_found = 1'b0;
      hit_idx   = '0;
      case (state_ff)
         ST_IDLE: begin
            rd_space = req_data.space;
            rd_idx   = lh_idx_ff[req_data.space];
            if (accept && (req_data.req_type == asl_pkg::REQ_LOOKUP)) begin
               state_in = ST_CHK_L;
            end
         end
         ST_CHK_L: begin
            if (cond_l && pr.hit) begin
               done      = 1'b1;
               hit_found = 1'b1;
               hit_idx   = l_ff;
               state_in  = ST_IDLE;
            end else begin
               rd_idx   = l_nx[IW-1:0];
               state_in = ST_CHK_N;
            end
         end
         ST_CHK_N: begin
            if (cond_n && pr.hit) begin
               done      = 1'b1;
               hit_found = 1'b1;
               hit_idx   = l_nx[IW-1:0];
               state_in  = ST_IDLE;
            end else begin
               rd_idx   = l_pv[IW-1:0];
               state_in = ST_CHK_P;
            end
         end
         ST_CHK_P: begin
            if (cond_p && pr.hit) begin
               done      = 1'b1;
               hit_found = 1'b1;
               hit_idx   = l_pv[IW-1:0];
               state_in  = ST_IDLE;
            end else begin
               lo_in    = plan_lo;
               hi_in    = plan_hi;
               mid_in   = plan_mid;
               rd_idx   = plan_idx;
               state_in = plan_more ? ST_SRCH : ST_FIN;
            end
         end
         ST_SRCH: begin
            if (pr.above) begin
               plan_lo = lo_ff;
               plan_hi = mid_ff;
            end else begin
               plan_lo = mid_ff;
               plan_hi = hi_ff;
            end
            lo_in    = plan_lo;
            hi_in    = plan_hi;
            mid_in   = plan_mid;
            rd_idx   = plan_idx;
            state_in = plan_more ? ST_SRCH : ST_FIN;
         end
         ST_FIN: begin
            done      = 1'b1;
            hit_found = ((lo_ff + NW'(1)) == hi_ff) && pr.hit;
            hit_idx   = lo_ff[IW-1:0];
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         phys_count_ff  <= '0;
         virt_count_ff  <= '0;
         lh_valid_ff[0] <= 1'b0;
         lh_valid_ff[1] <= 1'b0;
         lh_idx_ff[0]   <= '0;
         lh_idx_ff[1]   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= done;
         if (csr_we && (csr_index == asl_pkg::CSR_PHYSICAL_COUNT)) begin
            phys_count_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == asl_pkg::CSR_VIRTUAL_COUNT)) begin
            virt_count_ff <= csr_wdata;
         end
         if (done) begin
            lh_valid_ff[space_ff] <= hit_found;
            lh_idx_ff[space_ff]   <= hit_found ? hit_idx : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      if (accept) begin
         space_ff <= req_data.space;
         off_ff   <= req_data.lookup_offset;
         n_ff     <= n_eff;
         l_ff     <= lh_idx_ff[req_data.space];
         lv_ff    <= lh_valid_ff[req_data.space];
      end
      if (done) begin
         rsp_ff.segment_found <= hit_found;
         rsp_ff.segment_index <= hit_found ? 10'(hit_idx) : 10'd0;
         rsp_ff.section_found <= hit_found && rd_data.has_sections;
         rsp_ff.section_id    <= (hit_found && rd_data.has_sections) ?
                                 rd_data.first_section : 16'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_miss_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.segment_found) |-> !lh_valid_ff[space_ff])
      else $error("miss left a last-hit record behind");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH) |-> ((hi_ff - lo_ff) > NW'(1)))
      else $error("search step entered with a collapsed range");

   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a lookup in progress");
`endif

endmodule

// ===== rtl/asl_seg_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment table memory
// One write port and one read port with registered read data. Holds the
// physical table in the lower half and the virtual table in the upper half.
// ----------------------------------------------------------------------------
module asl_seg_mem #(
   parameter int ADDR_W = 11
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  asl_pkg::asl_entry_type wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output asl_pkg::asl_entry_type rd_data
);

   asl_pkg::asl_entry_type mem_ff [2**ADDR_W];
   asl_pkg::asl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/asl_probe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment probe unit
// Compares an offset against one half-open segment and reports whether the
// segment contains it or lies entirely above it.
// ----------------------------------------------------------------------------
module asl_probe (
   input  asl_pkg::asl_entry_type entry,
   input  logic [63:0]            offset,
   output asl_pkg::asl_probe_type result
);

   logic end_above;
   logic start_above;

   assign end_above   = entry.seg_end > offset;
   assign start_above = entry.seg_start > offset;

   assign result.hit   = end_above && !start_above;
   assign result.above = end_above && start_above;

endmodule

// ===== tb/address_segment_lookup_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address segment lookup unit testbench
// Loads sorted segment tables into both address spaces, programs the count
// registers through a range of settings and sends lookup requests that aim
// at segment interiors, boundaries and the neighbors of the last hit. A
// shadow copy of the tables and last-hit records predicts every response,
// and each response strobe is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module address_segment_lookup_unit_test;

   localparam int MAX_SEGMENTS = 1024;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_ITEMS = 500;
   localparam logic [asl_pkg::CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [asl_pkg::CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;
   localparam bit SPACE_PHYSICAL = 1'b0;
   localparam bit SPACE_VIRTUAL  = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   asl_pkg::asl_req_type req_data = '0;
   logic busy;
   logic rsp_valid;
   asl_pkg::asl_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [asl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [asl_pkg::COUNT_W-1:0] csr_wdata = '0;

   logic [63:0] shadow_start [2*MAX_SEGMENTS];
   logic [63:0] shadow_end [2*MAX_SEGMENTS];
   logic [15:0] shadow_section [2*MAX_SEGMENTS];
   bit shadow_covered [2*MAX_SEGMENTS];
   bit shadow_written [2*MAX_SEGMENTS];
   bit recent_valid [2];
   logic [9:0] recent_idx [2];
   logic [asl_pkg::COUNT_W-1:0] shadow_count [2];

   asl_pkg::asl_rsp_type pending_matches [$];
   int failures = 0;
   int request_count = 0;
   int idle_pct = 20;

   address_segment_lookup_unit #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #(15_000_000);
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int eff_count(logic [asl_pkg::COUNT_W-1:0] raw);
      if (raw == asl_pkg::COUNT_ALL_ONES) return 0;
      if (raw > MAX_SEGMENTS) return MAX_SEGMENTS;
      return int'(raw);
   endfunction

   function automatic int written_prefix(bit sp);
      int p;
      p = 0;
      while (p < MAX_SEGMENTS && shadow_written[int'(sp)*MAX_SEGMENTS + p]) p++;
      return p;
   endfunction

   // Returns -1 when the segment lies below the offset, 0 when it contains it
   // and 1 when it lies above it.
   function automatic int compare_segment(int slot, logic [63:0] off);
      if (shadow_end[slot] <= off) return -1;
      if (shadow_start[slot] <= off) return 0;
      return 1;
   endfunction

   function automatic asl_pkg::asl_rsp_type locate_segment(bit sp, logic [63:0] off);
      int n, base, l, lo, hi, mid, hit;
      bit found;
      asl_pkg::asl_rsp_type r;
      n = eff_count(shadow_count[sp]);
      base = int'(sp) * MAX_SEGMENTS;
      found = 1'b0;
      hit = 0;
      if (recent_valid[sp]) begin
         l = int'(recent_idx[sp]);
         if (l < n && compare_segment(base + l, off) == 0) begin
            hit = l;
            found = 1'b1;
         end else if (l + 1 < n && compare_segment(base + l + 1, off) == 0) begin
            hit = l + 1;
            found = 1'b1;
         end else if (l >= 1 && l - 1 < n && compare_segment(base + l - 1, off) == 0) begin
            hit = l - 1;
            found = 1'b1;
         end
      end
      if (!found) begin
         lo = 0;
         hi = n;
         while (lo + 1 < hi) begin
            mid = lo + (hi - lo) / 2;
            if (compare_segment(base + mid, off) > 0) hi = mid;
            else lo = mid;
         end
         if (lo + 1 == hi && compare_segment(base + lo, off) == 0) begin
            hit = lo;
            found = 1'b1;
         end
      end
      r = '0;
      if (found) begin
         recent_valid[sp] = 1'b1;
         recent_idx[sp] = 10'(hit);
         r.segment_found = 1'b1;
         r.segment_index = 10'(hit);
         r.section_found = shadow_covered[base + hit];
         r.section_id = shadow_covered[base + hit] ? shadow_section[base + hit] : 16'd0;
      end else begin
         recent_valid[sp] = 1'b0;
         recent_idx[sp] = '0;
      end
      return r;
   endfunction

   function automatic logic [63:0] pick_offset(bit sp);
      int n, idx, base;
      logic [63:0] s, e, off;
      n = eff_count(shadow_count[sp]);
      if (n == 0 || $urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return rand64();
         endcase
      end
      if (recent_valid[sp] && $urandom_range(0, 1) == 1)
         idx = int'(recent_idx[sp]) + int'($urandom_range(0, 2)) - 1;
      else
         idx = int'($urandom_range(0, n - 1));
      if (idx < 0) idx = 0;
      if (idx >= n) idx = n - 1;
      base = int'(sp) * MAX_SEGMENTS;
      s = shadow_start[base + idx];
      e = shadow_end[base + idx];
      case ($urandom_range(0, 7))
         0: off = s;
         1: off = e - 64'd1;
         2: off = e;
         3: off = s - 64'd1;
         default: off = (e > s) ? s + rand64() % (e - s) : s;
      endcase
      return off;
   endfunction

   always @(posedge clock) begin : check_responses
      asl_pkg::asl_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_matches.size() == 0) begin
            $error("Response arrived with no lookup outstanding.");
            failures++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_data.segment_found !== want.segment_found) begin
               $error("segment_found: expected %0d, actual %0d",
                      want.segment_found, rsp_data.segment_found);
               failures++;
            end
            if (rsp_data.segment_index !== want.segment_index) begin
               $error("segment_index: expected %0d, actual %0d",
                      want.segment_index, rsp_data.segment_index);
               failures++;
            end
            if (rsp_data.section_found !== want.section_found) begin
               $error("section_found: expected %0d, actual %0d",
                      want.section_found, rsp_data.section_found);
               failures++;
            end
            if (rsp_data.section_id !== want.section_id) begin
               $error("section_id: expected 0x%04h, actual 0x%04h",
                      want.section_id, rsp_data.section_id);
               failures++;
            end
         end
      end
   end

   task automatic pause_requests(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_request(input asl_pkg::asl_req_type item);
      int slot;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
         pause_requests($urandom_range(1, 14));
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      request_count++;
      if (item.req_type == asl_pkg::REQ_LOAD) begin
         slot = int'(item.space) * MAX_SEGMENTS + int'(item.entry_index);
         if (item.entry_index < MAX_SEGMENTS) begin
            shadow_start[slot] = item.seg_start;
            shadow_end[slot] = item.seg_end;
            shadow_section[slot] = item.first_section;
            shadow_covered[slot] = item.has_sections;
            shadow_written[slot] = 1'b1;
         end
      end else begin
         pending_matches.push_back(locate_segment(item.space, item.lookup_offset));
      end
   endtask

   task automatic load_entry(input bit sp, input logic [9:0] idx, input logic [63:0] s,
                             input logic [63:0] e, input logic [15:0] sec, input bit cov);
      asl_pkg::asl_req_type item;
      item.req_type = asl_pkg::REQ_LOAD;
      item.space = sp;
      item.entry_index = idx;
      item.seg_start = s;
      item.seg_end = e;
      item.first_section = sec;
      item.has_sections = cov;
      item.lookup_offset = rand64();
      send_request(item);
   endtask

   task automatic lookup(input bit sp, input logic [63:0] off);
      asl_pkg::asl_req_type item;
      item.req_type = asl_pkg::REQ_LOOKUP;
      item.space = sp;
      item.entry_index = 10'($urandom);
      item.seg_start = rand64();
      item.seg_end = rand64();
      item.first_section = 16'($urandom);
      item.has_sections = 1'($urandom);
      item.lookup_offset = off;
      send_request(item);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [asl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [asl_pkg::COUNT_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == asl_pkg::CSR_PHYSICAL_COUNT) shadow_count[SPACE_PHYSICAL] = value;
      else if (idx == asl_pkg::CSR_VIRTUAL_COUNT) shadow_count[SPACE_VIRTUAL] = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_count(input bit sp, input logic [asl_pkg::COUNT_W-1:0] value);
      wait_idle();
      csr_write(sp ? asl_pkg::CSR_VIRTUAL_COUNT : asl_pkg::CSR_PHYSICAL_COUNT, value);
   endtask

   // Fills slots 0 to n-1 with ascending segments spread over the whole
   // address range, with some adjacent, short, empty and inverted entries.
   task automatic build_table(input bit sp, input int n);
      logic [63:0] step_max, cursor, s, e, len;
      step_max = 64'hFFFF_FFFF_FFFF_FFFF / 64'(2 * n + 2);
      cursor = rand64() % step_max;
      for (int i = 0; i < n; i++) begin
         s = cursor + (($urandom_range(0, 3) == 0) ? 64'd0 : rand64() % step_max);
         len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 16))
                                           : rand64() % step_max + 64'd1;
         e = s + len;
         cursor = e;
         if ($urandom_range(0, 15) == 0) e = s - 64'($urandom_range(0, 1));
         load_entry(sp, 10'(i), s, e, 16'($urandom), 1'($urandom));
      end
   endtask

   task automatic run_lookups(input bit sp, input int k, input int noise_pct);
      for (int i = 0; i < k; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            load_entry(1'($urandom), 10'($urandom), rand64(), rand64(),
                       16'($urandom), 1'($urandom));
         else
            lookup(sp, pick_offset(sp));
      end
   endtask

   task automatic test_reset_state();
      lookup(SPACE_PHYSICAL, 64'd0);
      lookup(SPACE_PHYSICAL, '1);
      lookup(SPACE_VIRTUAL, 64'd0);
      lookup(SPACE_VIRTUAL, '1);
   endtask

   task automatic test_unknown_registers();
      wait_idle();
      csr_write(CSR_UNUSED_A, 11'd5);
      csr_write(CSR_UNUSED_B, asl_pkg::COUNT_ALL_ONES);
      lookup(SPACE_PHYSICAL, 64'd0);
      lookup(SPACE_VIRTUAL, 64'd0);
   endtask

   task automatic test_directed_segments();
      load_entry(SPACE_VIRTUAL, 10'd0, 64'h100, 64'h200, 16'h0001, 1'b1);
      load_entry(SPACE_VIRTUAL, 10'd1, 64'h200, 64'h300, 16'hABCD, 1'b0);
      load_entry(SPACE_VIRTUAL, 10'd2, 64'h400, 64'h3F0, 16'h1234, 1'b1);
      load_entry(SPACE_VIRTUAL, 10'd3, 64'h500, '1, 16'hFFFF, 1'b1);
      set_count(SPACE_VIRTUAL, 11'd4);
      lookup(SPACE_VIRTUAL, 64'h150);
      lookup(SPACE_VIRTUAL, 64'h250);
      lookup(SPACE_VIRTUAL, 64'h150);
      lookup(SPACE_VIRTUAL, 64'h250);
      lookup(SPACE_VIRTUAL, 64'h2FF);
      lookup(SPACE_VIRTUAL, 64'h300);
      lookup(SPACE_VIRTUAL, 64'h400);
      lookup(SPACE_VIRTUAL, 64'h500);
      lookup(SPACE_VIRTUAL, '1);
      lookup(SPACE_VIRTUAL, 64'h0FF);
      lookup(SPACE_VIRTUAL, 64'h100);
      lookup(SPACE_VIRTUAL, 64'hFFFF_FFFF_FFFF_FFFE);
      set_count(SPACE_VIRTUAL, 11'd1);
      lookup(SPACE_VIRTUAL, 64'h550);
      lookup(SPACE_VIRTUAL, 64'h150);
      set_count(SPACE_VIRTUAL, asl_pkg::COUNT_ALL_ONES);
      lookup(SPACE_VIRTUAL, 64'h150);
   endtask

   task automatic test_full_table();
      build_table(SPACE_PHYSICAL, MAX_SEGMENTS);
      set_count(SPACE_PHYSICAL, 11'd1024);
      run_lookups(SPACE_PHYSICAL, 200, 0);
      set_count(SPACE_PHYSICAL, 11'd1025);
      run_lookups(SPACE_PHYSICAL, 40, 0);
      set_count(SPACE_PHYSICAL, 11'd2046);
      run_lookups(SPACE_PHYSICAL, 40, 0);
      set_count(SPACE_PHYSICAL, asl_pkg::COUNT_ALL_ONES);
      run_lookups(SPACE_PHYSICAL, 10, 0);
      set_count(SPACE_PHYSICAL, 11'd1);
      run_lookups(SPACE_PHYSICAL, 20, 0);
      set_count(SPACE_PHYSICAL, 11'd0);
      run_lookups(SPACE_PHYSICAL, 10, 0);
   endtask

   task automatic test_random_phases();
      int first, n, p, r, c, pick;
      bit sp;
      first = request_count;
      while (request_count - first < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 2);
         idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
         sp = 1'($urandom);
         r = $urandom_range(0, 19);
         if (r < 15) n = $urandom_range(1, 16);
         else if (r < 19) n = $urandom_range(17, 128);
         else n = $urandom_range(129, MAX_SEGMENTS);
         build_table(sp, n);
         p = written_prefix(sp);
         r = $urandom_range(0, 19);
         if (r < 14) c = n;
         else if (r < 16) c = $urandom_range(0, p);
         else if (r == 16) c = 0;
         else if (r == 17) c = int'(asl_pkg::COUNT_ALL_ONES);
         else c = (p == MAX_SEGMENTS) ? $urandom_range(MAX_SEGMENTS + 1, 2046) : n;
         set_count(sp, 11'(c));
         run_lookups(sp, $urandom_range(20, 60), 8);
      end
   endtask

   task automatic test_back_to_back();
      idle_pct = 0;
      build_table(SPACE_VIRTUAL, 64);
      set_count(SPACE_VIRTUAL, 11'd64);
      run_lookups(SPACE_VIRTUAL, 150, 0);
   endtask

   initial begin
      for (int i = 0; i < 2*MAX_SEGMENTS; i++) shadow_written[i] = 1'b0;
      recent_valid[0] = 1'b0;
      recent_valid[1] = 1'b0;
      recent_idx[0] = '0;
      recent_idx[1] = '0;
      shadow_count[0] = '0;
      shadow_count[1] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_unknown_registers();
      test_directed_segments();
      test_full_table();
      test_random_phases();
      test_back_to_back();
      wait_idle();
      if (failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
